@@ src/slid_pkg.sv @@
// Shared constants and types for the sorted list insert/delete block.
package slid_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int RANK_W   = 4;
   localparam int CMP_W    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int ECNT_W   = 5;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_DELETE = 2'd1;

   localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_RANK_BAD  = 3'd5;

   typedef enum logic {
      RSP_EMPTY,
      RSP_HELD
   } rsp_state_type;

   typedef struct packed {
      logic exec;
   } dp_cmd_type;

endpackage

@@ src/slid_ctrl.sv @@
// Handshake controller: accepts a request beat and tracks the held response beat.
module slid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output slid_pkg::dp_cmd_type cmd
);

   slid_pkg::rsp_state_type state_ff, state_in;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slid_pkg::RSP_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         slid_pkg::RSP_EMPTY: begin
            req_tready = 1'b1;
         end
         slid_pkg::RSP_HELD: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
         end
         default: begin
            state_in = slid_pkg::RSP_EMPTY;
         end
      endcase
      accept   = req_tvalid && req_tready;
      cmd.exec = accept;
      if (accept) begin
         state_in = slid_pkg::RSP_HELD;
      end else if (rsp_tready && state_ff == slid_pkg::RSP_HELD) begin
         state_in = slid_pkg::RSP_EMPTY;
      end
   end

endmodule

@@ src/slid_dp.sv @@
// Datapath: sorted entry registers with parallel compare-and-shift, result register.
module slid_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  slid_pkg::dp_cmd_type              cmd,
   input  logic [1:0]                        func,
   input  logic [slid_pkg::VALUE_W-1:0]      value,
   input  logic [slid_pkg::RANK_W-1:0]       rank,
   input  logic                              from_end,
   output logic [slid_pkg::STATUS_W-1:0]     status,
   output logic [slid_pkg::VALUE_W-1:0]      read_value,
   output logic [slid_pkg::ECNT_W-1:0]       entry_count
);

   localparam int CAP = slid_pkg::CAPACITY;

   logic [slid_pkg::VALUE_W-1:0]  entries_ff [CAP];
   logic [slid_pkg::VALUE_W-1:0]  ins_entry  [CAP];
   logic [slid_pkg::VALUE_W-1:0]  del_entry  [CAP];
   logic [slid_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [slid_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [slid_pkg::VALUE_W-1:0]  rd_ff, rd_in;

   logic [CAP-1:0]                keep;
   logic [CAP-1:0]                eq;
   logic [CAP-1:0]                hit_upto;
   logic                          full;
   logic                          found;
   logic                          rank_ok;
   logic [slid_pkg::CMP_W-1:0]    idx_wide;
   logic [slid_pkg::IDX_W-1:0]    idx;
   logic                          wr_ins;
   logic                          wr_del;

   always_comb begin
      for (int i = 0; i < CAP; i++) begin
         keep[i] = (slid_pkg::CNT_W'(i) < count_ff) &&
                   ($signed(entries_ff[i]) <= $signed(value));
         eq[i]   = (slid_pkg::CNT_W'(i) < count_ff) && (entries_ff[i] == value);
      end
      // bits at and above the first match
      hit_upto = eq | (~eq + CAP'(1));
      found    = |eq;
      full     = count_ff == slid_pkg::CNT_W'(CAP);

      for (int i = 0; i < CAP; i++) begin
         if (keep[i]) begin
            ins_entry[i] = entries_ff[i];
         end else if (i == 0) begin
            ins_entry[i] = value;
         end else if (keep[(i == 0) ? 0 : i - 1]) begin
            ins_entry[i] = value;
         end else begin
            ins_entry[i] = entries_ff[(i == 0) ? 0 : i - 1];
         end
         if (hit_upto[i] && i < CAP - 1) begin
            del_entry[i] = entries_ff[(i < CAP - 1) ? i + 1 : i];
         end else begin
            del_entry[i] = entries_ff[i];
         end
      end

      rank_ok  = slid_pkg::CMP_W'(rank) < slid_pkg::CMP_W'(count_ff);
      idx_wide = from_end ?
                 (slid_pkg::CMP_W'(count_ff) - slid_pkg::CMP_W'(1) - slid_pkg::CMP_W'(rank)) :
                 slid_pkg::CMP_W'(rank);
      idx      = idx_wide[slid_pkg::IDX_W-1:0];

      wr_ins    = 1'b0;
      wr_del    = 1'b0;
      count_in  = count_ff;
      rd_in     = '0;
      case (func)
         slid_pkg::FUNC_INSERT: begin
            if (full) begin
               status_in = slid_pkg::ST_FULL;
            end else begin
               status_in = slid_pkg::ST_INSERTED;
               wr_ins    = 1'b1;
               count_in  = count_ff + slid_pkg::CNT_W'(1);
            end
         end
         slid_pkg::FUNC_DELETE: begin
            if (found) begin
               status_in = slid_pkg::ST_DELETED;
               wr_del    = 1'b1;
               count_in  = count_ff - slid_pkg::CNT_W'(1);
            end else begin
               status_in = slid_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            if (rank_ok) begin
               status_in = slid_pkg::ST_READ_OK;
               rd_in     = entries_ff[idx];
            end else begin
               status_in = slid_pkg::ST_RANK_BAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         rd_ff     <= rd_in;
         for (int i = 0; i < CAP; i++) begin
            if (wr_ins) begin
               entries_ff[i] <= ins_entry[i];
            end else if (wr_del) begin
               entries_ff[i] <= del_entry[i];
            end
         end
      end
   end

   assign status      = status_ff;
   assign read_value  = rd_ff;
   assign entry_count = slid_pkg::ECNT_W'(count_ff);

endmodule

@@ src/sorted_list_insert_delete.sv @@
// Top level of the sorted list block: stream ports, controller and datapath.
// Keeps up to 16 signed 32-bit values in ascending order. Each request beat is an
// insert, a delete or a read by rank, and yields exactly one response beat. Every
// operation completes in one step: the entry registers compare against the request
// value in parallel and shift together, so a new request beat is taken every cycle
// unless a response waits unclaimed; its response appears in the output register in
// the cycle after acceptance. The request side stays ready while the held response
// beat is being taken in the same cycle.
module sorted_list_insert_delete (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // func[1:0], value[33:2], rank[37:34], from_end[38], zero[39]
   input  logic [slid_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status[2:0], read_value[34:3], entry_count[39:35]
   output logic [slid_pkg::RSP_W-1:0]  rsp_tdata
);

   slid_pkg::dp_cmd_type              cmd;
   logic [slid_pkg::STATUS_W-1:0]     status;
   logic [slid_pkg::VALUE_W-1:0]      read_value;
   logic [slid_pkg::ECNT_W-1:0]       entry_count;

   slid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   slid_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .func        (req_tdata[1:0]),
      .value       (req_tdata[33:2]),
      .rank        (req_tdata[37:34]),
      .from_end    (req_tdata[38]),
      .status      (status),
      .read_value  (read_value),
      .entry_count (entry_count)
   );

   assign rsp_tdata = {entry_count, read_value, status};

endmodule

@@ verif/tb_sorted_list_insert_delete.sv @@
// Testbench for sorted_list_insert_delete: directed and random beats checked against a local model.
`timescale 1ns / 1ps

module tb_sorted_list_insert_delete;

   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_SPARE = 2'd3;   // unused code, decodes as read
   localparam logic signed [slid_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [slid_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 13;
   localparam int PHASE_BEATS    = 40;

   typedef struct packed {
      logic [slid_pkg::STATUS_W-1:0]       status;
      logic signed [slid_pkg::VALUE_W-1:0] read_value;
      logic [slid_pkg::ECNT_W-1:0]         entry_count;
   } rsp_beat_type;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [slid_pkg::REQ_W-1:0]  req_tdata;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [slid_pkg::RSP_W-1:0]  rsp_tdata;

   logic signed [slid_pkg::VALUE_W-1:0] sorted_vals[$];
   rsp_beat_type                        expected_rsps[$];
   int                                  fail_count;
   int                                  idle_cycles;
   int                                  burst_left;
   int                                  gap_pct;
   int                                  stall_pct;
   logic [5:0]                          stall_tick = '0;

   sorted_list_insert_delete uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Model of the sorted table; returns the response the beat must produce.
   function automatic rsp_beat_type apply_table_op(
         input logic [1:0] op,
         input logic signed [slid_pkg::VALUE_W-1:0] val,
         input logic [slid_pkg::RANK_W-1:0] rank,
         input logic from_end);
      rsp_beat_type rsp;
      int           pos;
      int           idx;
      rsp = '0;
      pos = 0;
      if (op == slid_pkg::FUNC_INSERT) begin
         if (sorted_vals.size() >= slid_pkg::CAPACITY) begin
            rsp.status = slid_pkg::ST_FULL;
         end else begin
            while (pos < sorted_vals.size() && sorted_vals[pos] <= val) pos++;
            sorted_vals.insert(pos, val);
            rsp.status = slid_pkg::ST_INSERTED;
         end
      end else if (op == slid_pkg::FUNC_DELETE) begin
         while (pos < sorted_vals.size() && sorted_vals[pos] != val) pos++;
         if (pos < sorted_vals.size()) begin
            sorted_vals.delete(pos);
            rsp.status = slid_pkg::ST_DELETED;
         end else begin
            rsp.status = slid_pkg::ST_NOT_FOUND;
         end
      end else begin
         if (int'(rank) < sorted_vals.size()) begin
            idx = from_end ? sorted_vals.size() - 1 - int'(rank) : int'(rank);
            rsp.read_value = sorted_vals[idx];
            rsp.status     = slid_pkg::ST_READ_OK;
         end else begin
            rsp.status = slid_pkg::ST_RANK_BAD;
         end
      end
      rsp.entry_count = slid_pkg::ECNT_W'(sorted_vals.size());
      return rsp;
   endfunction

   task automatic check_field(input string name, input logic [slid_pkg::VALUE_W-1:0] exp_v,
                              input logic [slid_pkg::VALUE_W-1:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // Response check first, then prediction of the request beat taken at this edge.
   always @(posedge clock) begin
      rsp_beat_type exp_rsp;
      rsp_beat_type act_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            act_rsp.status      = rsp_tdata[2:0];
            act_rsp.read_value  = rsp_tdata[34:3];
            act_rsp.entry_count = rsp_tdata[39:35];
            if (expected_rsps.size() == 0) begin
               $display("%0t unexpected response beat: expected none actual %0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("status", slid_pkg::VALUE_W'(exp_rsp.status),
                           slid_pkg::VALUE_W'(act_rsp.status));
               check_field("read_value", exp_rsp.read_value, act_rsp.read_value);
               check_field("entry_count", slid_pkg::VALUE_W'(exp_rsp.entry_count),
                           slid_pkg::VALUE_W'(act_rsp.entry_count));
            end
         end
         if (req_tvalid && req_tready)
            expected_rsps.push_back(apply_table_op(req_tdata[1:0], req_tdata[33:2],
                                                   req_tdata[37:34], req_tdata[38]));
      end
   end

   // Receiver: random stalls in alternate windows, always ready in between.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1'b1;
      rsp_tready <= stall_tick[5] ? 1'b1 : ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_op(input logic [1:0] op,
                          input logic signed [slid_pkg::VALUE_W-1:0] val,
                          input logic [slid_pkg::RANK_W-1:0] rank, input logic from_end);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(99) < gap_pct) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, from_end, rank, val, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_table();
      send_op(FUNC_READ, 0, 4'd0, 1'b1);
      send_op(slid_pkg::FUNC_DELETE, VAL_MIN, 4'd15, 1'b0);
      send_op(FUNC_READ, -1, 4'd0, 1'b0);
   endtask

   // Fill to capacity with extremes and duplicates, overflow, read both ends, delete.
   task automatic test_fill_and_full();
      logic signed [slid_pkg::VALUE_W-1:0] fill_vals[16];
      fill_vals = '{VAL_MAX, VAL_MIN, 0, -1, 1, 5, 5, 5, -5, 32'sh5555_5555,
                    32'shaaaa_aaaa, VAL_MAX, VAL_MIN, 100, -100, 7};
      foreach (fill_vals[i]) send_op(slid_pkg::FUNC_INSERT, fill_vals[i], 4'(i), i[0]);
      send_op(slid_pkg::FUNC_INSERT, 3, 4'd0, 1'b0);
      send_op(FUNC_READ, 0, 4'd15, 1'b0);
      send_op(FUNC_SPARE, 0, 4'd15, 1'b1);
      send_op(slid_pkg::FUNC_DELETE, 5, 4'd0, 1'b0);
      send_op(slid_pkg::FUNC_DELETE, 6, 4'd0, 1'b0);
   endtask

   task automatic test_random_ops();
      logic signed [slid_pkg::VALUE_W-1:0] pool[8];
      logic signed [slid_pkg::VALUE_W-1:0] val;
      logic [1:0]                          op;
      logic [slid_pkg::RANK_W-1:0]         rank;
      int                                  ins_pct;
      int                                  del_pct;
      int                                  pick;
      int                                  held;
      pool = '{VAL_MIN, VAL_MAX, 0, -1, 1, 2, 100, -100};
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase % 4)
            0: begin ins_pct = 70; del_pct = 15; gap_pct = 30; stall_pct = 30; end
            1: begin ins_pct = 15; del_pct = 65; gap_pct = 50; stall_pct = 60; end
            2: begin ins_pct = 40; del_pct = 30; gap_pct = 0;  stall_pct = 0;  end
            default: begin ins_pct = 85; del_pct = 5; gap_pct = 20; stall_pct = 80; end
         endcase
         for (int n = 0; n < PHASE_BEATS; n++) begin
            held = sorted_vals.size();
            pick = $urandom_range(99);
            if (pick < ins_pct)
               op = slid_pkg::FUNC_INSERT;
            else if (pick < ins_pct + del_pct)
               op = slid_pkg::FUNC_DELETE;
            else
               op = ($urandom_range(9) == 0) ? FUNC_SPARE : FUNC_READ;
            pick = $urandom_range(99);
            if (op == slid_pkg::FUNC_DELETE && held > 0 && pick < 70)
               val = sorted_vals[$urandom_range(held - 1)];
            else if (pick < 40)
               val = pool[$urandom_range(7)];
            else
               val = $urandom;
            rank = slid_pkg::RANK_W'($urandom_range(15));
            if (op[1] && held > 0 && $urandom_range(3) != 0)
               rank = slid_pkg::RANK_W'($urandom_range(held - 1));
            send_op(op, val, rank, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      fail_count  = 0;
      burst_left  = 0;
      gap_pct     = 25;
      stall_pct   = 40;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_and_full();
      wait_drained();
      test_random_ops();

      wait_drained();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
